// ===== rtl/core/positional_list_store_macros.svh =====
// Assertion helpers used by the RTL of the list store.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list store check failed");

// Next-cycle implication, checked out of reset.
`define PLST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list store check failed");

`endif

// ===== rtl/core/plst_pkg.sv =====
package plst_pkg;

   // Sizes
   localparam int CAPACITY    = 64;
   localparam int DATA_W      = 32;
   localparam int CMD_W       = 3;
   localparam int POS_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int LEN_W       = 7;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GROUP_SIZE  = 8;
   localparam int GROUP_COUNT = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CAPACITY);
   localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(CAPACITY);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_AT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic              del;
      logic              rd;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/plst_cell.sv =====
module plst_cell (
   input  logic                          clock,
   input  plst_pkg::cell_ctrl_type       ctrl,
   input  logic [plst_pkg::CMP_W-1:0]    cell_index,
   input  logic [plst_pkg::DATA_W-1:0]   prev_value,
   input  logic [plst_pkg::DATA_W-1:0]   next_value,
   output logic [plst_pkg::DATA_W-1:0]   value,
   output logic [plst_pkg::DATA_W-1:0]   hit_value
);
   import plst_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              hit;
   logic              above;

   assign hit   = (cell_index == ctrl.pos);
   assign above = (cell_index > ctrl.pos);

   // insert: shift up from the left neighbor; delete: pull from the right one
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins) begin
         if (above) begin
            value_in = prev_value;
         end else if (hit) begin
            value_in = ctrl.value;
         end
      end else if (ctrl.del) begin
         if (hit || above) begin
            value_in = next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign hit_value = hit ? value_ff : '0;

endmodule

// ===== rtl/core/plst_chain.sv =====
module plst_chain (
   input  logic                                               clock,
   input  plst_pkg::cell_ctrl_type                            ctrl,
   output logic [plst_pkg::GROUP_COUNT-1:0][plst_pkg::DATA_W-1:0] group_value
);
   import plst_pkg::*;

   logic [CAPACITY-1:0][DATA_W-1:0]    cell_value;
   logic [CAPACITY-1:0][DATA_W-1:0]    cell_hit;
   logic [GROUP_COUNT-1:0][DATA_W-1:0] group_ff;
   logic [GROUP_COUNT-1:0][DATA_W-1:0] group_in;

   // Row of cells, each wired to its neighbors; zero is fed in past either end
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] prev_value;
      logic [DATA_W-1:0] next_value;
      if (g == 0) begin : g_first
         assign prev_value = '0;
      end else begin : g_prev
         assign prev_value = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_next
         assign next_value = cell_value[g+1];
      end
      plst_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (CMP_W'(g)),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[g]),
         .hit_value  (cell_hit[g])
      );
   end

   // First level of the read tree: OR of the selected word within each group
   always_comb begin
      group_in = '0;
      for (int j = 0; j < GROUP_COUNT; j++) begin
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (j * GROUP_SIZE + k < CAPACITY) begin
               group_in[j] = group_in[j] | cell_hit[j * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         group_ff <= group_in;
      end
   end

   assign group_value = group_ff;

endmodule

// ===== rtl/core/positional_list_store.sv =====
// Positional list store: an ordered list of up to 64 signed 32-bit words.
// Request channel (req_valid/req_ready) carries one command word: req_cmd
// (read, insert at head, insert at tail, insert before position, delete),
// req_position and req_value. Each command gives exactly one response word
// on rsp_valid/rsp_ready: rsp_read_value, rsp_status and rsp_length.
// Every element lives in its own cell; an insert or delete shifts all cells
// behind the position together, so commands take the same time anywhere.
// Each accepted command passes through the middle stage, then the response
// register, which drives rsp_valid and the response word.
// Throughput: one command per cycle while the response side keeps up; the
// read path (cell select, group OR register, final OR) sets the latency.
// A stalled receiver holds the response register; one more command is
// accepted into the middle stage, then req_ready drops until space frees.
// Reset (synchronous) empties the list and drops both stages; the element
// cells are not cleared, since only positions below the length are read.
`include "positional_list_store_macros.svh"

module positional_list_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [plst_pkg::CMD_W-1:0]           req_cmd,
   input  logic [plst_pkg::POS_W-1:0]           req_position,
   input  logic signed [plst_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [plst_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [plst_pkg::STATUS_W-1:0]        rsp_status,
   output logic [plst_pkg::LEN_W-1:0]           rsp_length
);
   import plst_pkg::*;

   logic                                accept;
   logic                                s1_adv;
   logic                                full;
   logic [CMP_W-1:0]                    pos_ext;
   logic [CMP_W-1:0]                    cnt_ext;
   logic [CMP_W-1:0]                    pos_sel;
   logic                                ins_ok;
   logic                                del_ok;
   logic                                is_read;
   logic [STATUS_W-1:0]                 status_sel;
   cell_ctrl_type                       ctrl;
   logic [GROUP_COUNT-1:0][DATA_W-1:0]  group_value;
   logic [DATA_W-1:0]                   read_or;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_is_read_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [LEN_W-1:0]    s1_length_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_read_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]    rsp_length_ff;

   // Handshake
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // Command decode
   assign full    = (count_ff == COUNT_FULL);
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      ins_ok     = 1'b0;
      del_ok     = 1'b0;
      is_read    = 1'b0;
      status_sel = ST_DONE;
      pos_sel    = pos_ext;
      case (req_cmd)
         CMD_READ: begin
            is_read = 1'b1;
            if (pos_ext >= cnt_ext) begin
               status_sel = ST_RANGE;
            end
         end
         CMD_HEAD: begin
            pos_sel = '0;
            if (full) begin
               status_sel = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         CMD_TAIL: begin
            pos_sel = cnt_ext;
            if (full) begin
               status_sel = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         CMD_AT: begin
            if (pos_ext > cnt_ext) begin
               status_sel = ST_RANGE;
            end else if (full) begin
               status_sel = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               status_sel = ST_RANGE;
            end else begin
               del_ok = 1'b1;
            end
         end
         default: begin
            status_sel = ST_DONE;
         end
      endcase
   end

   // Cell broadcast
   always_comb begin
      ctrl.ins   = accept && ins_ok;
      ctrl.del   = accept && del_ok;
      ctrl.rd    = accept && is_read;
      ctrl.pos   = pos_sel;
      ctrl.value = req_value;
   end

   plst_chain u_chain (
      .clock       (clock),
      .ctrl        (ctrl),
      .group_value (group_value)
   );

   // Element count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.del) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Middle stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Last level of the read tree
   always_comb begin
      read_or = '0;
      for (int j = 0; j < GROUP_COUNT; j++) begin
         read_or = read_or | group_value[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Middle stage word
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_read_ff <= is_read;
         s1_status_ff  <= status_sel;
         s1_length_ff  <= LEN_W'(count_in);
      end
   end

   // Response word: -1 on a read out of range, zero for non-reads
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (!s1_is_read_ff) begin
            rsp_read_value_ff <= '0;
         end else if (s1_status_ff == ST_RANGE) begin
            rsp_read_value_ff <= '1;
         end else begin
            rsp_read_value_ff <= read_or;
         end
         rsp_status_ff <= s1_status_ff;
         rsp_length_ff <= s1_length_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

   // Checks
   `PLST_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_FULL)
   `PLST_ASSERT_NXT(a_ins_grows, clock, reset, ctrl.ins, count_ff == $past(count_ff) + 1'b1)
   `PLST_ASSERT_NXT(a_del_shrinks, clock, reset, ctrl.del, count_ff == $past(count_ff) - 1'b1)
   `PLST_ASSERT_IMP(a_full_len, clock, reset, rsp_valid_ff && rsp_status_ff == ST_FULL,
                    rsp_length_ff == LEN_FULL)
   `PLST_ASSERT_NXT(a_no_drop, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_ready,
                    s1_valid_ff)

endmodule

// ===== tb/sv/positional_list_store_test.sv =====
`timescale 1ns / 1ps

module positional_list_store_test;
   import plst_pkg::*;

   localparam logic [CMD_W-1:0] CMD_MAX      = CMD_W'((1 << CMD_W) - 1);
   localparam int               RANDOM_WORDS = 1600;
   localparam int               MAX_IDLE     = 16;
   localparam int               SHOWN_ERRORS = 10;
   localparam int               SETTLE_TIME  = 10;

   // one command word as planned for the request channel
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
      logic              drain;   // hold until all responses are back
   } list_cmd_type;

   // one response word as the list should produce it
   typedef struct packed {
      logic [DATA_W-1:0]   read_value;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } list_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [LEN_W-1:0]         rsp_length;

   list_cmd_type   pending_cmds[$];
   list_reply_type expected_replies[$];

   // predicted list contents
   logic [DATA_W-1:0] shadow_list[CAPACITY];
   int                shadow_len = 0;

   // length as the stimulus plan sees it, to aim positions
   int plan_len = 0;
   int random_count = 0;
   int mismatch_count = 0;

   int             hold_left = 0;
   int             stall_left = 0;
   logic           tx_burst = 1'b0;
   logic           rx_burst = 1'b0;
   list_cmd_type   next_cmd;
   list_reply_type want;

   positional_list_store u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   always #2 clock = ~clock;

   // Apply one accepted command to the shadow list, queue its response
   task automatic predict_list_reply(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] pos,
                                     input logic [DATA_W-1:0] value);
      list_reply_type r;
      int             at;
      logic           full;
      r = '0;
      at = -1;
      full = (shadow_len >= CAPACITY);
      case (cmd)
         CMD_READ: begin
            if (int'(pos) < shadow_len) begin
               r.read_value = shadow_list[pos];
            end else begin
               r.read_value = '1;
               r.status = ST_RANGE;
            end
         end
         CMD_HEAD: begin
            if (full) r.status = ST_FULL;
            else at = 0;
         end
         CMD_TAIL: begin
            if (full) r.status = ST_FULL;
            else at = shadow_len;
         end
         CMD_AT: begin
            // range test wins over full
            if (int'(pos) > shadow_len) r.status = ST_RANGE;
            else if (full) r.status = ST_FULL;
            else at = int'(pos);
         end
         CMD_DELETE: begin
            if (int'(pos) >= shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = int'(pos); i + 1 < shadow_len; i++)
                  shadow_list[i] = shadow_list[i + 1];
               shadow_len--;
            end
         end
         default: ;
      endcase
      // open a gap and drop the value in
      if (at >= 0) begin
         for (int i = shadow_len; i > at; i--)
            shadow_list[i] = shadow_list[i - 1];
         shadow_list[at] = value;
         shadow_len++;
      end
      r.length = LEN_W'(shadow_len);
      expected_replies.push_back(r);
   endtask

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
                                input logic [DATA_W-1:0] got_val);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("mismatch on %s: expected %0h, got %0h", what, exp_val, got_val);
   endtask

   // Queue a command and track the length it leaves behind
   task automatic plan_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                           input logic [DATA_W-1:0] value, input logic drain);
      list_cmd_type c;
      c.cmd = cmd;
      c.pos = POS_W'(pos);
      c.value = value;
      c.drain = drain;
      pending_cmds.push_back(c);
      case (cmd)
         CMD_HEAD, CMD_TAIL: if (plan_len < CAPACITY) plan_len++;
         CMD_AT: if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
         CMD_DELETE: if (pos < plan_len) plan_len--;
         default: ;
      endcase
      if (cmd <= CMD_DELETE) random_count++;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // mostly positions inside or just past the list, sometimes anything
   function automatic int pick_pos();
      if ($urandom_range(0, 6) == 0) return int'(POS_W'($urandom));
      return $urandom_range(0, plan_len);
   endfunction

   // Sender: one word per handshake, random idle after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_list_reply(req_cmd, req_position, req_value);
         if (!req_valid || req_ready) begin
            if (hold_left > 0) begin
               hold_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && expected_replies.size() != 0)) begin
               next_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_cmd <= next_cmd.cmd;
               req_position <= next_cmd.pos;
               req_value <= next_cmd.value;
               if ($urandom_range(0, 63) == 0) tx_burst = ~tx_burst;
               hold_left = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each response word, random stall after each
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               note_mismatch("response with nothing pending", '0, rsp_read_value);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_value !== want.read_value)
                  note_mismatch("read_value", want.read_value, rsp_read_value);
               if (rsp_status !== want.status)
                  note_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
               if (rsp_length !== want.length)
                  note_mismatch("length", DATA_W'(want.length), DATA_W'(rsp_length));
            end
            if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
            stall_left = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("positional_list_store_test: errors");
      $finish;
   end

   initial begin
      int          pick;
      logic [CMD_W-1:0] cmd;
      logic        drain;

      // directed: empty list, only element, ends of the value range, far positions, undefined commands
      plan_cmd(CMD_READ, 0, '0, 1'b0);
      plan_cmd(CMD_DELETE, 0, '0, 1'b0);
      plan_cmd(CMD_AT, 1, 32'h1234_5678, 1'b0);
      plan_cmd(CMD_AT, 0, 32'h8000_0000, 1'b0);
      plan_cmd(CMD_DELETE, 0, '0, 1'b0);
      plan_cmd(CMD_READ, 0, '0, 1'b0);
      plan_cmd(CMD_TAIL, 0, 32'h7FFF_FFFF, 1'b0);
      plan_cmd(CMD_HEAD, 0, '1, 1'b0);
      plan_cmd(CMD_AT, 2, '0, 1'b0);
      plan_cmd(CMD_AT, 1, 32'h5A5A_A5A5, 1'b0);
      for (int i = 0; i <= 4; i++) plan_cmd(CMD_READ, i, '1, 1'b0);
      plan_cmd(CMD_READ, (1 << POS_W) - 1, '0, 1'b0);
      plan_cmd(CMD_DELETE, (1 << POS_W) - 1, '0, 1'b0);
      plan_cmd(CMD_AT, (1 << POS_W) - 1, '1, 1'b0);
      for (int c = int'(CMD_DELETE) + 1; c <= int'(CMD_MAX); c++)
         plan_cmd(CMD_W'(c), (1 << POS_W) - 1, '1, 1'b0);
      plan_cmd(CMD_DELETE, 3, '0, 1'b0);
      plan_cmd(CMD_DELETE, 0, '0, 1'b0);
      plan_cmd(CMD_READ, 0, '0, 1'b0);
      plan_cmd(CMD_READ, 1, '0, 1'b0);

      // random phases; the first one waits for the directed words to drain
      random_count = 0;
      drain = 1'b1;
      while (random_count < RANDOM_WORDS) begin
         case ($urandom_range(0, 5))
            // fill to capacity, bounce off it, read the far end
            0: begin
               while (plan_len < CAPACITY) begin
                  pick = $urandom_range(0, 2);
                  cmd = (pick == 0) ? CMD_HEAD : (pick == 1) ? CMD_TAIL : CMD_AT;
                  plan_cmd(cmd, $urandom_range(0, plan_len), pick_value(), drain);
                  drain = 1'b0;
               end
               plan_cmd(CMD_HEAD, 0, pick_value(), 1'b0);
               plan_cmd(CMD_TAIL, 0, pick_value(), 1'b0);
               plan_cmd(CMD_AT, $urandom_range(0, CAPACITY), pick_value(), 1'b0);
               plan_cmd(CMD_AT, CAPACITY + 1, pick_value(), 1'b0);
               plan_cmd(CMD_READ, CAPACITY - 1, '0, 1'b0);
               plan_cmd(CMD_READ, CAPACITY, '0, 1'b0);
               plan_cmd(CMD_DELETE, CAPACITY - 1, '0, 1'b0);
            end
            // empty the list from random positions
            1: begin
               while (plan_len > 0) begin
                  if ($urandom_range(0, 3) == 0)
                     plan_cmd(CMD_READ, pick_pos(), '0, drain);
                  else
                     plan_cmd(CMD_DELETE, $urandom_range(0, plan_len - 1), pick_value(), drain);
                  drain = 1'b0;
               end
               plan_cmd(CMD_DELETE, 0, '0, 1'b0);
            end
            // general mix with some noise
            default: begin
               repeat (40) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 30) cmd = CMD_READ;
                  else if (pick < 45) cmd = CMD_HEAD;
                  else if (pick < 60) cmd = CMD_TAIL;
                  else if (pick < 80) cmd = CMD_AT;
                  else if (pick < 97) cmd = CMD_DELETE;
                  else cmd = CMD_W'($urandom_range(int'(CMD_DELETE) + 1, int'(CMD_MAX)));
                  plan_cmd(cmd, pick_pos(), pick_value(), drain);
                  drain = 1'b0;
               end
            end
         endcase
         drain = ($urandom_range(0, 2) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // let everything go out, come back and settle
      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
      if (mismatch_count == 0)
         $display("positional_list_store_test: clean");
      else
         $display("positional_list_store_test: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/plst_pkg.sv
rtl/core/plst_cell.sv
rtl/core/plst_chain.sv
rtl/core/positional_list_store.sv
tb/sv/positional_list_store_test.sv
